### design/assert_macros.svh
// Assertion macros shared by the camera coordinate frame parser RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge while out of reset.
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error(msg);

// Condition must never be seen at a rising edge while out of reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
	`ASSERT_PROP(lbl, clk_s, rstn_s, !(cond), msg)

`endif

### design/ccfp_pkg.sv
// Package for the camera coordinate frame parser: sizes, codes and beat types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ccfp_pkg;

	localparam int BUF_BYTES = 16;
	localparam int CNT_W     = $clog2(BUF_BYTES + 1);
	localparam int LEN_W     = 9;
	localparam int MODE_W    = 4;
	localparam int EV_W      = 3;
	localparam int X_W       = 9;
	localparam int Y_W       = 8;

	// Relative window: the twelve frame bytes before the newest one.
	localparam int WIN_DEPTH = 12;
	// Absolute positions read by pair mode.
	localparam int PAIR_LO   = 2;
	localparam int PAIR_HI   = 8;

	localparam logic [7:0] HEADER_BYTE = 8'h52;
	localparam logic [7:0] CATCH_CLR   = 8'h00;
	localparam logic [7:0] CATCH_SET   = 8'h01;

	// Receive phases
	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;

	// Task modes
	localparam logic [MODE_W-1:0] MODE_POINT_A = 4'd1;
	localparam logic [MODE_W-1:0] MODE_POINT_B = 4'd2;
	localparam logic [MODE_W-1:0] MODE_POINT_C = 4'd3;
	localparam logic [MODE_W-1:0] MODE_CORNERS = 4'd6;
	localparam logic [MODE_W-1:0] MODE_POINT_D = 4'd7;
	localparam logic [MODE_W-1:0] MODE_PAIR    = 4'd10;

	// Event kinds
	localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EV_W-1:0] EV_POINT   = 3'd1;
	localparam logic [EV_W-1:0] EV_CORNERS = 3'd2;
	localparam logic [EV_W-1:0] EV_PAIR    = 3'd3;
	localparam logic [EV_W-1:0] EV_LEN_ERR = 3'd4;

	typedef logic [WIN_DEPTH-1:0][7:0] win_t;
	typedef logic [PAIR_HI:PAIR_LO][7:0] pair_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       rearm_corners;
	} in_item_t;

	typedef struct packed {
		logic [EV_W-1:0] event_kind;
		logic [X_W-1:0]  x0;
		logic [Y_W-1:0]  y0;
		logic [X_W-1:0]  x1;
		logic [Y_W-1:0]  y1;
		logic [X_W-1:0]  x2;
		logic [Y_W-1:0]  y2;
		logic [X_W-1:0]  x3;
		logic [Y_W-1:0]  y3;
		logic            target_caught;
		logic            error_seen;
	} out_item_t;

	typedef struct packed {
		logic [X_W-1:0] x0;
		logic [Y_W-1:0] y0;
		logic [X_W-1:0] x1;
		logic [Y_W-1:0] y1;
		logic [X_W-1:0] x2;
		logic [Y_W-1:0] y2;
		logic [X_W-1:0] x3;
		logic [Y_W-1:0] y3;
	} coord_t;

	// What one processed byte yields.
	typedef struct packed {
		logic            fire;
		logic [EV_W-1:0] event_kind;
		logic            target_caught;
		logic            error_seen;
	} step_res_t;

endpackage

### design/ccfp_frame.sv
// Frame state for the camera coordinate frame parser: phase, counts, byte window,
// pair bytes and sticky flags. Depends on ccfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccfp_frame import ccfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  in_item_t          item,
	input  logic [MODE_W-1:0] task_mode,
	output win_t              win,
	output pair_t             pair,
	output step_res_t         res
);

	logic [1:0]       phase_q, phase_nx;
	logic [CNT_W-1:0] count_q, count_nx, count_inc;
	logic [CNT_W-1:0] len_q, len_nx;
	logic [LEN_W-1:0] len_ext;
	win_t             win_q, win_nx;
	pair_t            pair_q, pair_cur, pair_nx;
	logic             armed_q, armed_nx;
	logic             catch_q, catch_nx;
	logic             err_q, err_nx;
	logic [7:0]       b;

	assign b         = item.rx_byte;
	assign len_ext   = {1'b0, b} + LEN_W'(2);
	assign count_inc = count_q + CNT_W'(1);

	// Pair bytes with the current byte already written in.
	always_comb begin
		pair_cur = pair_q;
		for (int i = PAIR_LO; i <= PAIR_HI; i++) begin
			if ((phase_q == PH_LEN || phase_q == PH_DATA) && count_q == CNT_W'(i)) begin
				pair_cur[i] = b;
			end
		end
	end

	always_comb begin
		phase_nx       = phase_q;
		count_nx       = count_q;
		len_nx         = len_q;
		win_nx         = win_q;
		pair_nx        = pair_cur;
		armed_nx       = armed_q | item.rearm_corners;
		catch_nx       = catch_q;
		err_nx         = err_q;
		res.fire       = 1'b0;
		res.event_kind = EV_NONE;
		case (phase_q)
			PH_LEN: begin
				if (len_ext > LEN_W'(BUF_BYTES)) begin
					// too long: drop the frame, clear the buffer
					phase_nx       = PH_HUNT;
					err_nx         = 1'b1;
					pair_nx        = '0;
					res.fire       = 1'b1;
					res.event_kind = EV_LEN_ERR;
				end else begin
					len_nx   = len_ext[CNT_W-1:0];
					phase_nx = PH_DATA;
					win_nx   = {win_q[WIN_DEPTH-2:0], b};
					count_nx = count_inc;
				end
			end
			PH_DATA: begin
				win_nx   = {win_q[WIN_DEPTH-2:0], b};
				count_nx = count_inc;
				if (count_inc >= len_q) begin
					res.fire = 1'b1;
					phase_nx = PH_HUNT;
					count_nx = '0;
					case (task_mode)
						MODE_POINT_A, MODE_POINT_B, MODE_POINT_C, MODE_POINT_D: begin
							res.event_kind = EV_POINT;
						end
						MODE_CORNERS: begin
							if (armed_nx) begin
								res.event_kind = EV_CORNERS;
								armed_nx       = 1'b0;
							end
						end
						MODE_PAIR: begin
							res.event_kind = EV_PAIR;
							if (pair_cur[PAIR_LO] == CATCH_CLR) begin
								catch_nx = 1'b0;
							end else if (pair_cur[PAIR_LO] == CATCH_SET) begin
								catch_nx = 1'b1;
							end
						end
						default: begin
							res.event_kind = EV_NONE;
						end
					endcase
				end
			end
			default: begin
				phase_nx = PH_HUNT;
				if (b == HEADER_BYTE) begin
					win_nx    = '0;
					win_nx[0] = HEADER_BYTE;
					count_nx  = CNT_W'(1);
					phase_nx  = PH_LEN;
				end
			end
		endcase
		res.target_caught = catch_nx;
		res.error_seen    = err_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			len_q   <= '0;
			win_q   <= '0;
			pair_q  <= '0;
			armed_q <= 1'b0;
			catch_q <= 1'b0;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_nx;
			count_q <= count_nx;
			len_q   <= len_nx;
			win_q   <= win_nx;
			pair_q  <= pair_nx;
			armed_q <= armed_nx;
			catch_q <= catch_nx;
			err_q   <= err_nx;
		end
	end

	// Reads never reach the newest byte, so the stored window is used as is.
	assign win  = win_q;
	assign pair = pair_cur;

	`ASSERT_PROP(a_data_count, clk, arst_n, (phase_q == PH_DATA) |-> (count_q <= len_q), "frame count passed frame length")
	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(BUF_BYTES), "byte count beyond buffer")
	`ASSERT_NEVER(a_err_sticky, clk, arst_n, $fell(err_q), "sticky error cleared")
	`ASSERT_PROP(a_err_hunt, clk, arst_n, (step && res.event_kind == EV_LEN_ERR) |=> (phase_q == PH_HUNT), "length error did not return to hunting")

endmodule

### design/ccfp_extract.sv
// Coordinate extraction for the camera coordinate frame parser: sums and picks
// from the byte window or the pair bytes per event kind. Depends on ccfp_pkg.
`timescale 1ns / 1ps

module ccfp_extract import ccfp_pkg::*; (
	input  logic [EV_W-1:0] event_kind,
	input  win_t            win,
	input  pair_t           pair,
	output coord_t          crd
);

	function automatic logic [X_W-1:0] add_x(input logic [7:0] a, input logic [7:0] c);
		return {1'b0, a} + {1'b0, c};
	endfunction

	// win[k] holds the byte k+2 places back from the end of the frame.
	always_comb begin
		crd = '0;
		case (event_kind)
			EV_POINT: begin
				crd.x0 = add_x(win[2], win[0]);
				crd.y0 = win[1];
			end
			EV_CORNERS: begin
				crd.x0 = add_x(win[11], win[9]);
				crd.y0 = win[10];
				crd.x1 = add_x(win[8], win[6]);
				crd.y1 = win[7];
				crd.x2 = add_x(win[5], win[3]);
				crd.y2 = win[4];
				crd.x3 = add_x(win[2], win[0]);
				crd.y3 = win[1];
			end
			EV_PAIR: begin
				crd.x0 = add_x(pair[3], pair[5]);
				crd.y0 = pair[4];
				crd.x1 = add_x(pair[6], pair[8]);
				crd.y1 = pair[7];
			end
			default: begin
				crd = '0;
			end
		endcase
	end

endmodule

### design/camera_coordinate_frame_parser.sv
// Camera coordinate frame parser, top level.
// Depends on ccfp_pkg, ccfp_frame, ccfp_extract and assert_macros.svh.
//
// Usage:
//   rx channel (rx_valid/rx_ready/rx_item) takes one received byte per beat,
//   with rearm_corners to arm the corner capture ahead of that byte.
//   ev channel (ev_valid/ev_ready/ev_item) gives one beat when a frame
//   completes or is rejected for length; hunting bytes and bytes inside a
//   frame give none.
//   cfg_we/cfg_wdata write task_mode at any edge with cfg_we high; write it
//   only while no byte is in flight.
// Timing:
//   One byte per cycle sustained while the output register is free or
//   ev_ready is high. A byte is held in the input stage, parsed there, and
//   its event is loaded into the output register, which drives ev_valid.
//   The combinational parse (window sums, frame state update) sets this rate.
// Reset:
//   arst_n clears the frame state, buffer, flags and task_mode; the parser
//   starts hunting the 0x52 header.
// Stall:
//   While ev_ready is low and an event waits, the input stage holds its byte
//   and rx_ready drops once that stage is full; nothing is lost.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module camera_coordinate_frame_parser import ccfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_ready,
	input  in_item_t          rx_item,
	output logic              ev_valid,
	input  logic              ev_ready,
	output out_item_t         ev_item,
	input  logic              cfg_we,
	input  logic [MODE_W-1:0] cfg_wdata
);

	logic              rx_valid_s1;
	in_item_t          rx_item_s1;
	logic              ev_valid_s2;
	out_item_t         ev_item_s2;
	logic [MODE_W-1:0] task_mode_q;
	logic              advance;
	win_t              win;
	pair_t             pair;
	step_res_t         res;
	coord_t            crd;
	out_item_t         ev_item_nx;

	// Advance the input stage when the output register is free or draining.
	assign advance  = rx_valid_s1 && (!ev_valid_s2 || ev_ready);
	assign rx_ready = !rx_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_mode_q <= '0;
		end else if (cfg_we) begin
			task_mode_q <= cfg_wdata;
		end
	end

	// Input stage: hold the beat until it is parsed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			rx_valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			rx_item_s1 <= rx_item;
		end
	end

	ccfp_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (rx_item_s1),
		.task_mode (task_mode_q),
		.win       (win),
		.pair      (pair),
		.res       (res)
	);

	ccfp_extract u_extract (
		.event_kind (res.event_kind),
		.win        (win),
		.pair       (pair),
		.crd        (crd)
	);

	always_comb begin
		ev_item_nx.event_kind    = res.event_kind;
		ev_item_nx.x0            = crd.x0;
		ev_item_nx.y0            = crd.y0;
		ev_item_nx.x1            = crd.x1;
		ev_item_nx.y1            = crd.y1;
		ev_item_nx.x2            = crd.x2;
		ev_item_nx.y2            = crd.y2;
		ev_item_nx.x3            = crd.x3;
		ev_item_nx.y3            = crd.y3;
		ev_item_nx.target_caught = res.target_caught;
		ev_item_nx.error_seen    = res.error_seen;
	end

	// Output register: load on a firing byte, hold while waiting, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_s2 <= 1'b0;
		end else begin
			ev_valid_s2 <= (advance && res.fire) || (ev_valid_s2 && !ev_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.fire) begin
			ev_item_s2 <= ev_item_nx;
		end
	end

	assign ev_valid = ev_valid_s2;
	assign ev_item  = ev_item_s2;

	`ASSERT_PROP(a_ev_from_advance, clk, arst_n, $rose(ev_valid_s2) |-> $past(advance), "event raised without a parsed byte")
	`ASSERT_PROP(a_s1_hold, clk, arst_n, (rx_valid_s1 && !advance) |=> rx_valid_s1, "input stage lost a byte")

endmodule
